// File: hdl/frame_slot_ring_tracker_top_macros.svh
// Assertion macros shared by the frame slot ring tracker modules.
`ifndef FRAME_SLOT_RING_TRACKER_TOP_MACROS_SVH
`define FRAME_SLOT_RING_TRACKER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FSRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fsrt assertion failed");
`define FSRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fsrt assertion failed");
`else
`define FSRT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FSRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/fsrt_pkg.sv
// Types and constants of the frame slot ring tracker.
package fsrt_pkg;

	localparam int SLOTS_DEF = 8;
	localparam int DIM_W     = 13;
	localparam int STATUS_W  = 2;
	localparam int SLOT_W    = 3;
	localparam int HELD_W    = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_NATIVE_HEIGHT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NATIVE_WIDTH  = 1'd1;

	localparam logic [DIM_W-1:0] NATIVE_HEIGHT_RST = 13'd1080;
	localparam logic [DIM_W-1:0] NATIVE_WIDTH_RST  = 13'd1920;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [STATUS_W-1:0] ST_PUSH = 2'd0;
	localparam logic [STATUS_W-1:0] ST_READ = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

	typedef struct packed {
		logic set;
		logic clear;
		logic rot;
	} fsrt_op_t;

endpackage

// File: hdl/frame_slot_ring_tracker_top.sv
// Frame slot ring tracker: push and read requests over a ring of tagged frame slots.
// A push goes from acceptance to result by capturing the request, using the shared
// dimension comparator on the height, then on the width (tagging the slot on the width
// step), and loading the output register. A read steps one slot per cycle through the
// shared slot incrementer, over the distance k (1 to SLOTS) from the last read slot to
// the next held one; a read with nothing held goes straight to loading its result.
// A new request is taken as soon as the previous result sits in the output register; while
// that register still holds an unaccepted result, the next result waits and input stalls.
`include "frame_slot_ring_tracker_top_macros.svh"
module frame_slot_ring_tracker_top
	import fsrt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 command,
	input  logic [DIM_W-1:0]     frame_height,
	input  logic [DIM_W-1:0]     frame_width,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STATUS_W-1:0]  status,
	output logic [SLOT_W-1:0]    slot,
	output logic                 rotated,
	output logic [HELD_W-1:0]    frames_held
);

	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP_H,
		S_CMP_W,
		S_SEARCH,
		S_RESP
	} state_t;

	state_t              state_q;
	logic [DIM_W-1:0]    native_height_q;
	logic [DIM_W-1:0]    native_width_q;
	logic [DIM_W-1:0]    h_q;
	logic [DIM_W-1:0]    w_q;
	logic                eq_q;
	logic [SW-1:0]       wr_slot_q;
	logic [SW-1:0]       rd_slot_q;
	logic [SW-1:0]       ptr_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [SW-1:0]       res_slot_q;
	logic                res_rot_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                rotated_q;
	logic [HELD_W-1:0]   frames_held_q;

	logic [DIM_W-1:0]       eq_a;
	logic [DIM_W-1:0]       eq_b;
	logic                   dim_eq;
	logic [SW-1:0]          inc_in;
	logic [SW-1:0]          inc_out;
	logic [SW-1:0]          idx;
	fsrt_op_t               op;
	logic                   hit;
	logic                   rot_rd;
	logic [CW-1:0]          held_cnt;
	logic                   can_out;
	logic [SLOT_W+SW-1:0]   slot_ext;
	logic [HELD_W+CW-1:0]   held_ext;

	fsrt_tag_store #(
		.SLOTS(SLOTS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (idx),
		.op     (op),
		.hit    (hit),
		.rot_rd (rot_rd),
		.count  (held_cnt)
	);

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign slot        = slot_q;
	assign rotated     = rotated_q;
	assign frames_held = frames_held_q;
	assign can_out     = !out_valid_q || out_ready;
	assign slot_ext    = {{SLOT_W{1'b0}}, res_slot_q};
	assign held_ext    = {{HELD_W{1'b0}}, held_cnt};

	always_comb begin
		eq_a   = (state_q == S_CMP_H) ? h_q : w_q;
		eq_b   = (state_q == S_CMP_H) ? native_height_q : native_width_q;
		dim_eq = (eq_a == eq_b);

		case (state_q)
			S_IDLE:  inc_in = rd_slot_q;
			S_CMP_W: inc_in = wr_slot_q;
			default: inc_in = ptr_q;
		endcase
		inc_out = (inc_in == SW'(SLOTS - 1)) ? '0 : inc_in + SW'(1);

		idx = (state_q == S_CMP_W) ? wr_slot_q : ptr_q;
		op.set   = (state_q == S_CMP_W);
		op.rot   = !(eq_q && dim_eq);
		op.clear = (state_q == S_SEARCH) && hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			native_height_q <= NATIVE_HEIGHT_RST;
			native_width_q  <= NATIVE_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NATIVE_HEIGHT: native_height_q <= cfg_data;
				CFG_NATIVE_WIDTH:  native_width_q  <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			h_q           <= '0;
			w_q           <= '0;
			eq_q          <= 1'b0;
			wr_slot_q     <= '0;
			rd_slot_q     <= '0;
			ptr_q         <= '0;
			res_status_q  <= ST_PUSH;
			res_slot_q    <= '0;
			res_rot_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			status_q      <= ST_PUSH;
			slot_q        <= '0;
			rotated_q     <= 1'b0;
			frames_held_q <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_RESP)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						h_q <= frame_height;
						w_q <= frame_width;
						if (command == CMD_PUSH) begin
							state_q <= S_CMP_H;
						end else if (held_cnt == '0) begin
							res_status_q <= ST_NONE;
							res_slot_q   <= '0;
							res_rot_q    <= 1'b0;
							state_q      <= S_RESP;
						end else begin
							ptr_q   <= inc_out;
							state_q <= S_SEARCH;
						end
					end
				end
				S_CMP_H: begin
					eq_q    <= dim_eq;
					state_q <= S_CMP_W;
				end
				S_CMP_W: begin
					res_status_q <= ST_PUSH;
					res_slot_q   <= wr_slot_q;
					res_rot_q    <= op.rot;
					wr_slot_q    <= inc_out;
					state_q      <= S_RESP;
				end
				S_SEARCH: begin
					if (hit) begin
						res_status_q <= ST_READ;
						res_slot_q   <= ptr_q;
						rd_slot_q    <= ptr_q;
						state_q      <= S_RESP;
					end else begin
						ptr_q <= inc_out;
					end
				end
				S_RESP: begin
					if (can_out) begin
						out_valid_q   <= 1'b1;
						status_q      <= res_status_q;
						slot_q        <= slot_ext[SLOT_W-1:0];
						rotated_q     <= (res_status_q == ST_READ) ? rot_rd : res_rot_q;
						frames_held_q <= held_ext[HELD_W-1:0];
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`FSRT_ASSERT_NOW(a_search_has_frame, clk, arst_n, state_q == S_SEARCH, held_cnt != '0)
	`FSRT_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, in_valid && in_ready, state_q != S_IDLE)
	`FSRT_ASSERT_NOW(a_push_result_held, clk, arst_n, state_q == S_RESP && res_status_q == ST_PUSH, held_cnt != '0)

endmodule

// File: hdl/fsrt_tag_store.sv
// Slot tag store: held flags, orientation memory and held-frame count.
`include "frame_slot_ring_tracker_top_macros.svh"
module fsrt_tag_store
	import fsrt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF,
	localparam int SW = $clog2(SLOTS),
	localparam int CW = $clog2(SLOTS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [SW-1:0] idx,
	input  fsrt_op_t      op,
	output logic          hit,
	output logic          rot_rd,
	output logic [CW-1:0] count
);

	logic [SLOTS-1:0] held_q;
	logic [CW-1:0]    count_q;
	logic             rot_mem [SLOTS];
	logic             rot_rd_q;

	assign hit    = held_q[idx];
	assign rot_rd = rot_rd_q;
	assign count  = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			count_q <= '0;
		end else if (op.set) begin
			held_q[idx] <= 1'b1;
			if (!held_q[idx])
				count_q <= count_q + CW'(1);
		end else if (op.clear) begin
			held_q[idx] <= 1'b0;
			if (held_q[idx])
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (op.set)
			rot_mem[idx] <= op.rot;
		rot_rd_q <= rot_mem[idx];
	end

	`FSRT_ASSERT_NOW(a_count_matches, clk, arst_n, 1'b1, count_q == CW'($countones(held_q)))
	`FSRT_ASSERT_NOW(a_op_exclusive, clk, arst_n, 1'b1, !(op.set && op.clear))
	`FSRT_ASSERT_NEXT(a_clear_drops, clk, arst_n, op.clear && hit, count_q == $past(count_q) - CW'(1))

endmodule

// File: tb/sv/tb_frame_slot_ring_tracker_top.sv
// Self-checking testbench for the frame slot ring tracker: directed table, then random requests.
module tb_frame_slot_ring_tracker_top;
	import fsrt_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int RANDOM_PER_PHASE = 130;
	localparam int DRAIN_CYCLES = 16;

	typedef enum logic [1:0] {
		TAG_EMPTY    = 2'd0,
		TAG_ORIGINAL = 2'd1,
		TAG_ROTATED  = 2'd2
	} slot_tag_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic                rotated;
		logic [HELD_W-1:0]   held;
	} slot_result_t;

	typedef struct packed {
		logic                cmd;
		logic [DIM_W-1:0]    height;
		logic [DIM_W-1:0]    width;
		logic                typed;
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic                rotated;
		logic [HELD_W-1:0]   held;
	} directed_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic                command;
	logic [DIM_W-1:0]    frame_height;
	logic [DIM_W-1:0]    frame_width;
	logic                out_valid;
	logic                out_ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic                rotated;
	logic [HELD_W-1:0]   frames_held;

	frame_slot_ring_tracker_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.frame_height (frame_height),
		.frame_width  (frame_width),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.slot         (slot),
		.rotated      (rotated),
		.frames_held  (frames_held)
	);

	slot_tag_t        ring_tags [SLOTS_DEF];
	int unsigned      write_ptr;
	int unsigned      read_ptr;
	logic [DIM_W-1:0] native_h;
	logic [DIM_W-1:0] native_w;

	slot_result_t pending_results [$];

	int unsigned mismatches;
	int unsigned cycles;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_left;
	bit          hold_request;
	int unsigned push_count;
	int unsigned rotated_push_count;
	int unsigned read_count;
	int unsigned empty_read_count;
	int unsigned overwrite_count;

	directed_row_t directed_rows [24] = '{
		'{CMD_READ, 13'd0,    13'd0,    1'b1, ST_NONE, 3'd0, 1'b0, 4'd0},
		'{CMD_PUSH, 13'd1080, 13'd1920, 1'b1, ST_PUSH, 3'd0, 1'b0, 4'd1},
		'{CMD_PUSH, 13'd1920, 13'd1080, 1'b1, ST_PUSH, 3'd1, 1'b1, 4'd2},
		'{CMD_PUSH, 13'd1,    13'd1,    1'b1, ST_PUSH, 3'd2, 1'b1, 4'd3},
		'{CMD_PUSH, 13'd8191, 13'd8191, 1'b1, ST_PUSH, 3'd3, 1'b1, 4'd4},
		'{CMD_PUSH, 13'd1080, 13'd1921, 1'b1, ST_PUSH, 3'd4, 1'b1, 4'd5},
		'{CMD_PUSH, 13'd1081, 13'd1920, 1'b1, ST_PUSH, 3'd5, 1'b1, 4'd6},
		'{CMD_PUSH, 13'd0,    13'd0,    1'b1, ST_PUSH, 3'd6, 1'b1, 4'd7},
		'{CMD_PUSH, 13'd1080, 13'd1920, 1'b1, ST_PUSH, 3'd7, 1'b0, 4'd8},
		'{CMD_PUSH, 13'd1080, 13'd1920, 1'b1, ST_PUSH, 3'd0, 1'b0, 4'd8},
		'{CMD_READ, 13'd8191, 13'd8191, 1'b1, ST_READ, 3'd1, 1'b1, 4'd7},
		'{CMD_READ, 13'd0,    13'd0,    1'b0, ST_READ, 3'd0, 1'b0, 4'd0},
		'{CMD_READ, 13'd0,    13'd0,    1'b0, ST_READ, 3'd0, 1'b0, 4'd0},
		'{CMD_READ, 13'd0,    13'd0,    1'b0, ST_READ, 3'd0, 1'b0, 4'd0},
		'{CMD_READ, 13'd0,    13'd0,    1'b0, ST_READ, 3'd0, 1'b0, 4'd0},
		'{CMD_READ, 13'd0,    13'd0,    1'b0, ST_READ, 3'd0, 1'b0, 4'd0},
		'{CMD_READ, 13'd0,    13'd0,    1'b0, ST_READ, 3'd0, 1'b0, 4'd0},
		'{CMD_READ, 13'd0,    13'd0,    1'b0, ST_READ, 3'd0, 1'b0, 4'd0},
		'{CMD_READ, 13'd0,    13'd0,    1'b1, ST_NONE, 3'd0, 1'b0, 4'd0},
		'{CMD_PUSH, 13'd8191, 13'd1,    1'b0, ST_PUSH, 3'd0, 1'b0, 4'd0},
		'{CMD_PUSH, 13'd1,    13'd8191, 1'b0, ST_PUSH, 3'd0, 1'b0, 4'd0},
		'{CMD_READ, 13'd0,    13'd0,    1'b0, ST_READ, 3'd0, 1'b0, 4'd0},
		'{CMD_READ, 13'd0,    13'd0,    1'b0, ST_READ, 3'd0, 1'b0, 4'd0},
		'{CMD_READ, 13'd8191, 13'd8191, 1'b1, ST_NONE, 3'd0, 1'b0, 4'd0}
	};

	initial begin
		clk = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned held_count();
		int unsigned n;
		n = 0;
		for (int i = 0; i < SLOTS_DEF; i++) begin
			if (ring_tags[i] != TAG_EMPTY)
				n++;
		end
		return n;
	endfunction

	function automatic slot_result_t track_request(input logic cmd, input logic [DIM_W-1:0] h,
			input logic [DIM_W-1:0] w);
		slot_result_t r;
		int unsigned  pos;
		r = '0;
		if (cmd == CMD_PUSH) begin
			pos = write_ptr;
			if (ring_tags[pos] != TAG_EMPTY)
				overwrite_count++;
			ring_tags[pos] = (h == native_h && w == native_w) ? TAG_ORIGINAL : TAG_ROTATED;
			r.status = ST_PUSH;
			r.slot = pos[SLOT_W-1:0];
			r.rotated = (ring_tags[pos] == TAG_ROTATED);
			write_ptr = (pos + 1) % SLOTS_DEF;
			push_count++;
			if (r.rotated)
				rotated_push_count++;
		end else if (held_count() == 0) begin
			r.status = ST_NONE;
			empty_read_count++;
		end else begin
			pos = read_ptr;
			for (int k = 0; k < SLOTS_DEF; k++) begin
				pos = (pos + 1) % SLOTS_DEF;
				if (ring_tags[pos] != TAG_EMPTY)
					break;
			end
			read_ptr = pos;
			r.status = ST_READ;
			r.slot = pos[SLOT_W-1:0];
			r.rotated = (ring_tags[pos] == TAG_ROTATED);
			ring_tags[pos] = TAG_EMPTY;
			read_count++;
		end
		r.held = HELD_W'(held_count());
		return r;
	endfunction

	task automatic send_request(input logic cmd, input logic [DIM_W-1:0] h,
			input logic [DIM_W-1:0] w, input bit typed, input slot_result_t want);
		slot_result_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		frame_height <= h;
		frame_width <= w;
		do
			@(posedge clk);
		while (!in_ready);
		r = track_request(cmd, h, w);
		pending_results.push_back(typed ? want : r);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_NATIVE_HEIGHT)
			native_h = val;
		else
			native_w = val;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_OFF_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		slot_result_t got;
		slot_result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{status, slot, rotated, frames_held};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d slot %0d rotated %0d held %0d",
						got.status, got.slot, got.rotated, got.held);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected status %0d slot %0d rotated %0d held %0d,",
							" got status %0d slot %0d rotated %0d held %0d"},
							want.status, want.slot, want.rotated, want.held,
							got.status, got.slot, got.rotated, got.held);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", pending_results.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		slot_result_t     want;
		logic             cmd;
		logic [DIM_W-1:0] h;
		logic [DIM_W-1:0] w;
		int unsigned      push_pct;
		int unsigned      pick;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_NATIVE_HEIGHT;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_PUSH;
		frame_height = '0;
		frame_width = '0;
		out_ready = 1'b0;
		mismatches = 0;
		cycles = 0;
		send_idle_pct = 26;
		recv_idle_pct = 73;
		hold_left = 0;
		hold_request = 1'b0;
		push_count = 0;
		rotated_push_count = 0;
		read_count = 0;
		empty_read_count = 0;
		overwrite_count = 0;
		push_pct = 50;
		for (int i = 0; i < SLOTS_DEF; i++)
			ring_tags[i] = TAG_EMPTY;
		write_ptr = 0;
		read_ptr = 0;
		native_h = NATIVE_HEIGHT_RST;
		native_w = NATIVE_WIDTH_RST;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			want = '{directed_rows[i].status, directed_rows[i].slot,
				directed_rows[i].rotated, directed_rows[i].held};
			send_request(directed_rows[i].cmd, directed_rows[i].height,
				directed_rows[i].width, directed_rows[i].typed, want);
		end
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					write_register(CFG_NATIVE_HEIGHT, 13'd1);
					write_register(CFG_NATIVE_WIDTH, 13'd8191);
					send_idle_pct = 26;
					recv_idle_pct = 73;
				end
				1: begin
					write_register(CFG_NATIVE_HEIGHT, 13'd8191);
					write_register(CFG_NATIVE_WIDTH, 13'd1);
					send_idle_pct = 73;
					recv_idle_pct = 26;
				end
				2: begin
					write_register(CFG_NATIVE_HEIGHT, DIM_W'($urandom_range(8191, 1)));
					write_register(CFG_NATIVE_WIDTH, DIM_W'($urandom_range(8191, 1)));
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				default: begin
					write_register(CFG_NATIVE_HEIGHT, 13'd8191);
					write_register(CFG_NATIVE_WIDTH, 13'd8191);
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_request = 1'b1;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (n % 16 == 0) begin
					pick = $urandom_range(2);
					push_pct = (pick == 0) ? 20 : (pick == 1) ? 50 : 80;
				end
				cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_READ;
				pick = $urandom_range(99);
				if (pick < 40) begin
					h = native_h;
					w = native_w;
				end else if (pick < 55) begin
					h = native_h;
					w = DIM_W'($urandom_range(8191, 1));
				end else if (pick < 70) begin
					h = DIM_W'($urandom_range(8191, 1));
					w = native_w;
				end else begin
					h = DIM_W'($urandom_range(8191, 1));
					w = DIM_W'($urandom_range(8191, 1));
				end
				send_request(cmd, h, w, 1'b0, '0);
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d pushes (%0d rotated, %0d overwrites), %0d reads, %0d empty reads",
			push_count, rotated_push_count, overwrite_count, read_count, empty_read_count);
		$display("over five dimension settings, three idle patterns and one long output stall");
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAIL");
		end
		$finish;
	end

endmodule
